// ===== rtl/wsp_pkg.sv =====
// Shared types, constants and microcode table of the wheel speed PID step core.
package wsp_pkg;

  localparam int WHEELS     = 4;
  localparam int SLOT_W     = (WHEELS > 1) ? $clog2(WHEELS) : 1;
  localparam int WHEEL_W    = 2;
  localparam int FIELD_W    = 16;
  localparam int MAG_W      = FIELD_W + 1;
  localparam int LIMIT_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int INTEG_W    = 21;
  localparam int ERR_W      = 18;
  localparam int DER_W      = 17;
  localparam int OPB_W      = INTEG_W + 1;
  localparam int OPA_W      = FIELD_W + 1;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int ACC_W      = 40;
  localparam int FRAC_W     = 8;
  localparam int PC_W       = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INT_GAIN    = 3'd1,
    REG_DER_GAIN    = 3'd2,
    REG_RPM_PER_TK  = 3'd3,
    REG_INT_LIMIT   = 3'd4,
    REG_DRIVE_MIN   = 3'd5,
    REG_DRIVE_MAX   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [FIELD_W-1:0] prop_gain;
    logic [FIELD_W-1:0] int_gain_dt;
    logic [FIELD_W-1:0] der_gain_per_dt;
    logic [FIELD_W-1:0] rpm_per_tick;
    logic [LIMIT_W-1:0] integral_limit;
    logic [FIELD_W-1:0] drive_min;
    logic [FIELD_W-1:0] drive_max;
  } cfg_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_REQ,
    COND_KD_ZERO,
    COND_OUT_FULL
  } cond_e;

  typedef enum logic [1:0] {
    A_RPM,
    A_KP,
    A_KI,
    A_KD
  } a_sel_e;

  typedef enum logic [1:0] {
    B_TICKS,
    B_ERR,
    B_INTEG,
    B_DERIV
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SCALE
  } acc_op_e;

  typedef struct packed {
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            last;
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    logic            mul_en;
    acc_op_e         acc_op;
    logic            speed_ld;
    logic            integ_ld;
    logic            drive_ld;
    logic            out_ld;
  } uword_t;

  typedef struct packed {
    logic    capture;
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    logic    mul_en;
    acc_op_e acc_op;
    logic    speed_ld;
    logic    integ_ld;
    logic    drive_ld;
    logic    out_ld;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_START = '0;

  localparam uword_t UW_NOP = '{cond: COND_NONE, target: PC_START, last: 1'b0,
                                a_sel: A_RPM, b_sel: B_TICKS, mul_en: 1'b0,
                                acc_op: ACC_HOLD, speed_ld: 1'b0, integ_ld: 1'b0,
                                drive_ld: 1'b0, out_ld: 1'b0};

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UW_NOP;
    case (pc)
      4'd0: begin
        w.cond   = COND_NO_REQ;
        w.target = 4'd0;
      end
      4'd1: begin
        w.a_sel  = A_RPM;
        w.b_sel  = B_TICKS;
        w.mul_en = 1'b1;
      end
      4'd2: begin
        w.speed_ld = 1'b1;
      end
      4'd3: begin
        w.integ_ld = 1'b1;
        w.a_sel    = A_KP;
        w.b_sel    = B_ERR;
        w.mul_en   = 1'b1;
      end
      4'd4: begin
        w.acc_op = ACC_LOAD;
        w.a_sel  = A_KI;
        w.b_sel  = B_INTEG;
        w.mul_en = 1'b1;
      end
      4'd5: begin
        w.acc_op = ACC_ADD;
        w.a_sel  = A_KD;
        w.b_sel  = B_DERIV;
        w.mul_en = 1'b1;
        w.cond   = COND_KD_ZERO;
        w.target = 4'd7;
      end
      4'd6: begin
        w.acc_op = ACC_ADD;
      end
      4'd7: begin
        w.acc_op = ACC_SCALE;
      end
      4'd8: begin
        w.drive_ld = 1'b1;
      end
      4'd9: begin
        w.out_ld = 1'b1;
        w.cond   = COND_OUT_FULL;
        w.target = 4'd9;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [MAG_W-1:0] mag17(input logic [FIELD_W-1:0] v);
    logic signed [MAG_W-1:0] sx;
    sx = {v[FIELD_W-1], v};
    return v[FIELD_W-1] ? MAG_W'(-sx) : MAG_W'(sx);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [WHEEL_W-1:0] wheel);
    logic [4:0] w;
    w = 5'(wheel);
    for (int k = 0; k < 3; k++) begin
      if (w >= 5'(WHEELS)) w = w - 5'(WHEELS);
    end
    return w[SLOT_W-1:0];
  endfunction

endpackage

// ===== rtl/wsp_if.sv =====
// Request channel interfaces: item input, result output and register write.
interface wsp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [wsp_pkg::WHEEL_W-1:0]          wheel;
  logic signed [wsp_pkg::FIELD_W-1:0]   tick_delta;
  logic signed [wsp_pkg::FIELD_W-1:0]   target_rpm;
  modport source (output valid, wheel, tick_delta, target_rpm, input ready);
  modport sink   (input valid, wheel, tick_delta, target_rpm, output ready);
endinterface

interface wsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [wsp_pkg::WHEEL_W-1:0]  wheel_out;
  logic [wsp_pkg::FIELD_W-1:0]  speed_rpm;
  logic [wsp_pkg::FIELD_W-1:0]  drive;
  modport source (output valid, wheel_out, speed_rpm, drive, input ready);
  modport sink   (input valid, wheel_out, speed_rpm, drive, output ready);
endinterface

interface wsp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wsp_pkg::CFG_IDX_W-1:0]   index;
  logic [wsp_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/wsp_cfg_regs.sv =====
// Configuration register file with reset values and write decode.
module wsp_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_valid_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]    wr_index_i,
  input  logic [wsp_pkg::CFG_DATA_W-1:0]   wr_data_i,
  output logic                             wr_ready_o,
  output wsp_pkg::cfg_t                    cfg_o
);
  import wsp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        REG_PROP_GAIN:  cfg_d.prop_gain       = wr_data_i[FIELD_W-1:0];
        REG_INT_GAIN:   cfg_d.int_gain_dt     = wr_data_i[FIELD_W-1:0];
        REG_DER_GAIN:   cfg_d.der_gain_per_dt = wr_data_i[FIELD_W-1:0];
        REG_RPM_PER_TK: cfg_d.rpm_per_tick    = wr_data_i[FIELD_W-1:0];
        REG_INT_LIMIT:  cfg_d.integral_limit  = wr_data_i[LIMIT_W-1:0];
        REG_DRIVE_MIN:  cfg_d.drive_min       = wr_data_i[FIELD_W-1:0];
        REG_DRIVE_MAX:  cfg_d.drive_max       = wr_data_i[FIELD_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= 16'd128;
      cfg_q.int_gain_dt     <= 16'd13;
      cfg_q.der_gain_per_dt <= 16'd0;
      cfg_q.rpm_per_tick    <= 16'd1536;
      cfg_q.integral_limit  <= 20'd3000;
      cfg_q.drive_min       <= 16'd1;
      cfg_q.drive_max       <= 16'd65535;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/wsp_sequencer.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module wsp_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_full_i,
  input  logic           kd_zero_i,
  output logic           in_ready_o,
  output wsp_pkg::ctrl_t ctrl_o
);
  import wsp_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            cond_hit;

  assign uw         = ucode(pc_q);
  assign in_ready_o = (pc_q == PC_START);

  always_comb begin
    case (uw.cond)
      COND_NONE:     cond_hit = 1'b0;
      COND_NO_REQ:   cond_hit = !in_valid_i;
      COND_KD_ZERO:  cond_hit = kd_zero_i;
      COND_OUT_FULL: cond_hit = out_full_i;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      pc_d = uw.target;
    end else if (uw.last) begin
      pc_d = PC_START;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_comb begin
    ctrl_o.capture  = in_ready_o && in_valid_i;
    ctrl_o.a_sel    = uw.a_sel;
    ctrl_o.b_sel    = uw.b_sel;
    ctrl_o.mul_en   = uw.mul_en;
    ctrl_o.acc_op   = uw.acc_op;
    ctrl_o.speed_ld = uw.speed_ld;
    ctrl_o.integ_ld = uw.integ_ld;
    ctrl_o.drive_ld = uw.drive_ld;
    ctrl_o.out_ld   = uw.out_ld && !out_full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_START;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/wsp_datapath.sv =====
// Datapath: shared multiplier, accumulator, per-wheel state and result register.
module wsp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wsp_pkg::ctrl_t                      ctrl_i,
  input  wsp_pkg::cfg_t                       cfg_i,
  input  logic [wsp_pkg::WHEEL_W-1:0]         wheel_i,
  input  logic [wsp_pkg::FIELD_W-1:0]         tick_delta_i,
  input  logic [wsp_pkg::FIELD_W-1:0]         target_rpm_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [wsp_pkg::WHEEL_W-1:0]         wheel_out_o,
  output logic [wsp_pkg::FIELD_W-1:0]         speed_rpm_o,
  output logic [wsp_pkg::FIELD_W-1:0]         drive_o,
  output logic                                out_full_o
);
  import wsp_pkg::*;

  logic [WHEEL_W-1:0]        wheel_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [MAG_W-1:0]          ticks_q, target_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [FIELD_W-1:0]        speed_q, speed_c;
  logic signed [ERR_W-1:0]   err_q, err_c;
  logic signed [DER_W-1:0]   der_q, der_c;
  logic signed [INTEG_W-1:0] integ_q, integ_c;
  logic signed [ACC_W-1:0]   acc_q, acc_d, acc_bias, acc_sum, prod_ext;
  logic [FIELD_W-1:0]        drive_q, drive_c;
  logic signed [INTEG_W-1:0] integral_q [WHEELS];
  logic [FIELD_W-1:0]        last_q [WHEELS];
  logic signed [INTEG_W:0]   isum, lim_pos, lim_neg;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [ACC_W-1:0]   dmax, dmin, hi_c;
  logic                      out_valid_q;
  logic [WHEEL_W-1:0]        out_wheel_q;
  logic [FIELD_W-1:0]        out_speed_q, out_drive_q;

  always_comb begin
    case (ctrl_i.a_sel)
      A_RPM:   op_a = $signed({1'b0, cfg_i.rpm_per_tick});
      A_KP:    op_a = $signed({1'b0, cfg_i.prop_gain});
      A_KI:    op_a = $signed({1'b0, cfg_i.int_gain_dt});
      A_KD:    op_a = $signed({1'b0, cfg_i.der_gain_per_dt});
      default: op_a = '0;
    endcase
    case (ctrl_i.b_sel)
      B_TICKS: op_b = $signed({{(OPB_W-MAG_W){1'b0}}, ticks_q});
      B_ERR:   op_b = $signed({{(OPB_W-ERR_W){err_q[ERR_W-1]}}, err_q});
      B_INTEG: op_b = $signed({integ_q[INTEG_W-1], integ_q});
      B_DERIV: op_b = $signed({{(OPB_W-DER_W){der_q[DER_W-1]}}, der_q});
      default: op_b = '0;
    endcase
    prod_d = op_a * op_b;
  end

  always_comb begin
    speed_c = (|prod_q[PROD_W-1:FRAC_W+FIELD_W]) ? {FIELD_W{1'b1}}
                                                : prod_q[FRAC_W+FIELD_W-1:FRAC_W];
    err_c   = $signed({1'b0, target_q}) - $signed({2'b0, speed_c});
    der_c   = $signed({1'b0, speed_c}) - $signed({1'b0, last_q[slot_q]});
  end

  always_comb begin
    isum    = $signed({integral_q[slot_q][INTEG_W-1], integral_q[slot_q]})
            + $signed({{(INTEG_W+1-ERR_W){err_q[ERR_W-1]}}, err_q});
    lim_pos = $signed({2'b0, cfg_i.integral_limit});
    lim_neg = -lim_pos;
    if (isum > lim_pos) begin
      integ_c = lim_pos[INTEG_W-1:0];
    end else if (isum < lim_neg) begin
      integ_c = lim_neg[INTEG_W-1:0];
    end else begin
      integ_c = isum[INTEG_W-1:0];
    end
  end

  always_comb begin
    prod_ext = $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q});
    acc_bias = $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{acc_q[ACC_W-1]}}});
    acc_sum  = acc_q + acc_bias;
    case (ctrl_i.acc_op)
      ACC_HOLD:  acc_d = acc_q;
      ACC_LOAD:  acc_d = prod_ext;
      ACC_ADD:   acc_d = acc_q + prod_ext;
      ACC_SCALE: acc_d = acc_sum >>> FRAC_W;
      default:   acc_d = acc_q;
    endcase
  end

  always_comb begin
    dmax    = $signed({{(ACC_W-FIELD_W){1'b0}}, cfg_i.drive_max});
    dmin    = $signed({{(ACC_W-FIELD_W){1'b0}}, cfg_i.drive_min});
    hi_c    = (acc_q > dmax) ? dmax : acc_q;
    drive_c = (hi_c < dmin) ? cfg_i.drive_min : hi_c[FIELD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      wheel_q  <= wheel_i;
      slot_q   <= slot_of(wheel_i);
      ticks_q  <= mag17(tick_delta_i);
      target_q <= mag17(target_rpm_i);
    end
    if (ctrl_i.mul_en) prod_q <= prod_d;
    if (ctrl_i.speed_ld) begin
      speed_q <= speed_c;
      err_q   <= err_c;
      der_q   <= der_c;
    end
    if (ctrl_i.integ_ld) integ_q <= integ_c;
    acc_q <= acc_d;
    if (ctrl_i.drive_ld) drive_q <= drive_c;
    if (ctrl_i.out_ld) begin
      out_wheel_q <= wheel_q;
      out_speed_q <= speed_q;
      out_drive_q <= drive_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WHEELS; k++) begin
        integral_q[k] <= '0;
        last_q[k]     <= '0;
      end
    end else begin
      if (ctrl_i.speed_ld) last_q[slot_q] <= speed_c;
      if (ctrl_i.integ_ld) integral_q[slot_q] <= integ_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_full_o  = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign wheel_out_o = out_wheel_q;
  assign speed_rpm_o = out_speed_q;
  assign drive_o     = out_drive_q;

endmodule

// ===== rtl/wheel_speed_pid_step_core.sv =====
// Top level of the per-wheel speed PID step core.
//
// item_i carries one request per control period: wheel number, signed
// encoder tick delta and signed target speed. result_o returns one result
// per item: the wheel, the saturated speed magnitude and the clamped drive.
// cfg_i writes the seven gain and limit registers by index; it is always
// ready. Writes must be made while no item is in flight; the block does not enforce it.
// A microcoded sequencer steps a ten-word control store over one shared
// 17x22 multiplier and a 40-bit accumulator; the four multiplies of an item
// are serialized on that multiplier.
// When the derivative gain is zero the sequencer skips the derivative
// accumulate step. One item is in flight at a time; item_i is ready again
// the cycle after the result is loaded.
// The result register frees the datapath: a new item is taken while the
// previous result waits. If the receiver stalls and the next result is
// done, the sequencer holds on its final step until the register drains.
// Reset loads the register defaults, zeros each wheel's integral and last
// speed, and leaves the block idle and ready.
module wheel_speed_pid_step_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsp_in_if.sink     item_i,
  wsp_out_if.source  result_o,
  wsp_cfg_if.sink    cfg_i
);
  import wsp_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  out_full;

  wsp_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  wsp_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .out_full_i (out_full),
    .kd_zero_i  (cfg.der_gain_per_dt == '0),
    .in_ready_o (item_i.ready),
    .ctrl_o     (ctrl)
  );

  wsp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg),
    .wheel_i      (item_i.wheel),
    .tick_delta_i (item_i.tick_delta),
    .target_rpm_i (item_i.target_rpm),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .wheel_out_o  (result_o.wheel_out),
    .speed_rpm_o  (result_o.speed_rpm),
    .drive_o      (result_o.drive),
    .out_full_o   (out_full)
  );

endmodule

// ===== rtl/wsp_checker.sv =====
// Port-level checker for the PID step core and its bind to the top level.
module wsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [wsp_pkg::WHEEL_W-1:0]  wheel_out_i,
  input logic [wsp_pkg::FIELD_W-1:0]  speed_rpm_i,
  input logic [wsp_pkg::FIELD_W-1:0]  drive_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(wheel_out_i) && $stable(speed_rpm_i) && $stable(drive_i))
    else $error("result payload changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in flight");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without an item in flight");

endmodule

bind wheel_speed_pid_step_core wsp_checker u_wsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .wheel_out_i (result_o.wheel_out),
  .speed_rpm_i (result_o.speed_rpm),
  .drive_i     (result_o.drive)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the wheel speed PID step core with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import wsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned RANDOM_PER_PHASE = 225;
  localparam int unsigned RANDOM_PHASES    = 6;
  localparam int unsigned MAX_PRINTS       = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam cfg_t RESET_CFG = '{prop_gain: 16'd128, int_gain_dt: 16'd13,
                                 der_gain_per_dt: 16'd0, rpm_per_tick: 16'd1536,
                                 integral_limit: 20'd3000, drive_min: 16'd1,
                                 drive_max: 16'hFFFF};
  localparam cfg_t FULL_CFG = '{prop_gain: 16'hFFFF, int_gain_dt: 16'hFFFF,
                                der_gain_per_dt: 16'hFFFF, rpm_per_tick: 16'hFFFF,
                                integral_limit: 20'hFFFFF, drive_min: 16'd0,
                                drive_max: 16'hFFFF};

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [FIELD_W-1:0] ticks;
    logic [FIELD_W-1:0] target;
  } step_req_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [FIELD_W-1:0] speed;
    logic [FIELD_W-1:0] drive;
  } drive_rec_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_SPARSE
  } sink_mode_e;

  class pid_drive_scoreboard;
    cfg_t                       gains;
    logic signed [INTEG_W-1:0]  integral_sum [WHEELS];
    logic [FIELD_W-1:0]         prev_speed [WHEELS];
    drive_rec_t                 expected_drives [$];
    int unsigned                errors;

    function new();
      gains  = RESET_CFG;
      errors = 0;
      foreach (integral_sum[k]) begin
        integral_sum[k] = '0;
        prev_speed[k]   = '0;
      end
    endfunction

    function longint magnitude(logic [FIELD_W-1:0] v);
      return v[FIELD_W-1] ? 65536 - longint'(v) : longint'(v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:  gains.prop_gain       = data[FIELD_W-1:0];
        REG_INT_GAIN:   gains.int_gain_dt     = data[FIELD_W-1:0];
        REG_DER_GAIN:   gains.der_gain_per_dt = data[FIELD_W-1:0];
        REG_RPM_PER_TK: gains.rpm_per_tick    = data[FIELD_W-1:0];
        REG_INT_LIMIT:  gains.integral_limit  = data[LIMIT_W-1:0];
        REG_DRIVE_MIN:  gains.drive_min       = data[FIELD_W-1:0];
        REG_DRIVE_MAX:  gains.drive_max       = data[FIELD_W-1:0];
        default: ;
      endcase
    endfunction

    function void add_control_step(step_req_t r);
      drive_rec_t rec;
      int         slot;
      longint     spd, err, integ, lim, der, sum, q;
      slot  = int'(r.wheel) % WHEELS;
      spd   = (magnitude(r.ticks) * longint'(gains.rpm_per_tick)) >>> 8;
      if (spd > 65535) spd = 65535;
      err   = magnitude(r.target) - spd;
      lim   = longint'(gains.integral_limit);
      integ = longint'(integral_sum[slot]) + err;
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      integral_sum[slot] = INTEG_W'(integ);
      der = spd - longint'(prev_speed[slot]);
      prev_speed[slot] = spd[FIELD_W-1:0];
      sum = longint'(gains.prop_gain) * err + longint'(gains.int_gain_dt) * integ
          + longint'(gains.der_gain_per_dt) * der;
      // integer division truncates toward zero
      q = sum / 256;
      if (q > longint'(gains.drive_max)) q = longint'(gains.drive_max);
      if (q < longint'(gains.drive_min)) q = longint'(gains.drive_min);
      rec.wheel = r.wheel;
      rec.speed = spd[FIELD_W-1:0];
      rec.drive = q[FIELD_W-1:0];
      expected_drives.push_back(rec);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("ERROR: %s", what);
    endtask

    task check_drive(logic [WHEEL_W-1:0] wheel, logic [FIELD_W-1:0] speed,
                     logic [FIELD_W-1:0] drive);
      drive_rec_t want;
      if (expected_drives.size() == 0) begin
        report($sformatf("result with no request pending: wheel %0d speed %0d drive %0d",
                         wheel, speed, drive));
        return;
      end
      want = expected_drives.pop_front();
      if (wheel !== want.wheel)
        report($sformatf("wheel_out %0d, predicted %0d", wheel, want.wheel));
      if (speed !== want.speed)
        report($sformatf("wheel %0d speed_rpm %0d, predicted %0d", want.wheel, speed,
                         want.speed));
      if (drive !== want.drive)
        report($sformatf("wheel %0d drive %0d, predicted %0d", want.wheel, drive,
                         want.drive));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycles = 0;
  bit hold_due = 1'b0;
  cfg_t active_cfg;
  int wheel_goal [WHEELS];
  step_req_t stim [$];
  pid_drive_scoreboard sb;

  wsp_in_if  item_bus ();
  wsp_out_if result_bus ();
  wsp_cfg_if cfg_bus ();

  wheel_speed_pid_step_core u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready)
      sb.check_drive(result_bus.wheel_out, result_bus.speed_rpm, result_bus.drive);
  end

  initial begin : result_sink
    sink_mode_e mode;
    int unsigned span;
    result_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_due) begin
        hold_due = 1'b0;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = sink_mode_e'($urandom_range(0, 3));
        span = $urandom_range(16, 160);
        for (int unsigned k = 0; k < span; k++) begin
          case (mode)
            SINK_OPEN:     result_bus.ready <= 1'b1;
            SINK_COIN:     result_bus.ready <= 1'($urandom_range(0, 1));
            SINK_PERIODIC: result_bus.ready <= (k % 5) != 4;
            SINK_SPARSE:   result_bus.ready <= ($urandom_range(0, 7) == 0);
            default:       result_bus.ready <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [FIELD_W-1:0] corner16();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      3:       return 16'($urandom_range(0, 1023));
      default: return 16'($urandom_range(64, 1536));
    endcase
  endfunction

  // Mostly closed-loop style sequences: ticks track each wheel's goal speed.
  function automatic step_req_t next_random_req();
    step_req_t r;
    int unsigned pick;
    int goal, spin, rate;
    r.wheel = WHEEL_W'($urandom_range(0, WHEELS - 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      r.ticks  = 16'($urandom);
      r.target = 16'($urandom);
    end else if (pick == 1) begin
      r.ticks  = corner16();
      r.target = corner16();
    end else begin
      if ($urandom_range(0, 19) == 0)
        wheel_goal[r.wheel] = ($urandom_range(0, 1) ? -1 : 1) * int'($urandom_range(0, 6000));
      goal = wheel_goal[r.wheel];
      rate = int'(active_cfg.rpm_per_tick);
      spin = (rate == 0) ? int'($urandom_range(0, 500))
                         : ((goal < 0 ? -goal : goal) * 256) / rate;
      spin = spin + int'($urandom_range(0, 16)) - 8;
      if (spin < 0) spin = 0;
      if (spin > 32767) spin = 32767;
      r.ticks  = 16'((goal < 0) ? -spin : spin);
      r.target = 16'(goal);
    end
    return r;
  endfunction

  function automatic void push_req(int w, int ticks, int target);
    step_req_t r;
    r.wheel  = WHEEL_W'(w);
    r.ticks  = 16'(ticks);
    r.target = 16'(target);
    stim.push_back(r);
  endfunction

  task automatic offer_all();
    step_req_t r;
    int unsigned burst, gap;
    burst = $urandom_range(1, 24);
    while (stim.size() != 0) begin
      r = stim.pop_front();
      item_bus.valid      <= 1'b1;
      item_bus.wheel      <= r.wheel;
      item_bus.tick_delta <= r.ticks;
      item_bus.target_rpm <= r.target;
      do @(posedge clk); while (!item_bus.ready);
      sb.add_control_step(r);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          item_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    item_bus.valid <= 1'b0;
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_reg(idx, data);
  endtask

  // Upper data bits above a 16-bit register carry junk; the block must drop them.
  task automatic load_regs(cfg_t c);
    put_reg(REG_PROP_GAIN,  {4'($urandom), c.prop_gain});
    put_reg(REG_INT_GAIN,   {4'($urandom), c.int_gain_dt});
    put_reg(REG_DER_GAIN,   {4'($urandom), c.der_gain_per_dt});
    put_reg(REG_RPM_PER_TK, {4'($urandom), c.rpm_per_tick});
    put_reg(REG_INT_LIMIT,  c.integral_limit);
    put_reg(REG_DRIVE_MIN,  {4'($urandom), c.drive_min});
    put_reg(REG_DRIVE_MAX,  {4'($urandom), c.drive_max});
    put_reg(REG_UNUSED,     20'($urandom));
    cfg_bus.valid <= 1'b0;
    active_cfg = c;
  endtask

  task automatic settle();
    while (sb.expected_drives.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin : stimulus
    cfg_t c;
    sb = new();
    active_cfg = RESET_CFG;
    foreach (wheel_goal[k]) wheel_goal[k] = 0;
    rst_n               <= 1'b0;
    item_bus.valid      <= 1'b0;
    item_bus.wheel      <= '0;
    item_bus.tick_delta <= '0;
    item_bus.target_rpm <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: field extremes, speed saturation, integral clamp both ways
    push_req(0, 0, 0);
    push_req(1, -32768, -32768);
    push_req(2, 32767, 32767);
    push_req(3, -1, -1);
    push_req(0, 1, 100);
    push_req(1, 0, 32767);
    push_req(1, 0, 32767);
    push_req(2, 32767, 0);
    push_req(3, 5000, -32768);
    offer_all();
    settle();

    // derivative path active
    c = '{prop_gain: 16'd256, int_gain_dt: 16'd512, der_gain_per_dt: 16'd1024,
          rpm_per_tick: 16'd256, integral_limit: 20'hFFFFF, drive_min: 16'd0,
          drive_max: 16'hFFFF};
    load_regs(c);
    push_req(0, 1000, 1000);
    push_req(0, 3000, 1000);
    push_req(0, -3000, -2000);
    push_req(1, 32767, -32768);
    push_req(1, -32768, 0);
    push_req(2, 0, 1);
    offer_all();
    settle();

    // crossed drive limits
    c.drive_min = 16'd40000;
    c.drive_max = 16'd10;
    load_regs(c);
    push_req(0, 0, 32767);
    push_req(1, 32767, 0);
    push_req(2, 100, 100);
    offer_all();
    settle();

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          c = RESET_CFG;
          c.der_gain_per_dt = 16'd64;
        end
        1: c = '0;
        2: c = FULL_CFG;
        default: begin
          c.prop_gain       = pick16();
          c.int_gain_dt     = pick16();
          c.der_gain_per_dt = pick16();
          c.rpm_per_tick    = pick16();
          c.integral_limit  = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                          : 20'($urandom_range(0, 40000));
          c.drive_min       = 16'($urandom_range(0, 3000));
          c.drive_max       = 16'($urandom_range(1000, 65535));
        end
      endcase
      load_regs(c);
      if (ph == 0) hold_due = 1'b1;
      repeat (RANDOM_PER_PHASE) stim.push_back(next_random_req());
      offer_all();
      settle();
    end

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
